// ----- hdl/upd_pkg.sv -----
`timescale 1ns / 1ps
// types, character constants and the hex digit decoder shared by the
// url percent decoder; no dependencies

package upd_pkg;

  localparam logic [7:0] ChPlus    = 8'h2B;
  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChSpace   = 8'h20;

  // what the front end holds between input beats
  localparam logic [1:0] HeldNone  = 2'd0;
  localparam logic [1:0] HeldPct   = 2'd1;
  localparam logic [1:0] HeldDigit = 2'd2;

  localparam int unsigned MaxBytes = 3;

  // one queued group of decoded bytes, cnt is 1 to 3
  typedef struct packed {
    logic [1:0]                   cnt;
    logic [MaxBytes-1:0][7:0]     data;
    logic                         last;
  } upd_entry_t;

  // returns {valid, nibble}
  function automatic logic [4:0] hex_nibble(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end
    return r;
  endfunction

endpackage

// ----- hdl/upd_if.sv -----
`timescale 1ns / 1ps
// stream interfaces for encoded input beats and decoded output beats
// standalone, no package needed

interface upd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface upd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

// ----- hdl/upd_front.sv -----
`timescale 1ns / 1ps
// front end: holds '%' and a first digit, turns each input beat into a
// group of zero to three decoded bytes; uses upd_pkg and upd_in_if

module upd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  upd_in_if.sink              in_i,
  input  logic                full_i,
  output logic                push_o,
  output upd_pkg::upd_entry_t entry_o
);

  logic [1:0] held_count_q, held_count_d;
  logic [7:0] held_digit_q, held_digit_d;

  logic       accept;
  logic [4:0] nib, hi_nib;
  logic       p_emit, p_hold;
  logic [7:0] p_byte;
  logic [1:0] n;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign nib        = upd_pkg::hex_nibble(in_i.in_byte);
  assign hi_nib     = upd_pkg::hex_nibble(held_digit_q);

  // the byte treated as if nothing were held
  always_comb begin
    p_emit = 1'b1;
    p_hold = 1'b0;
    p_byte = in_i.in_byte;
    if (in_i.in_byte == upd_pkg::ChPlus) begin
      p_byte = upd_pkg::ChSpace;
    end else if (in_i.in_byte == upd_pkg::ChPercent && !in_i.in_last) begin
      p_emit = 1'b0;
      p_hold = 1'b1;
    end
  end

  always_comb begin
    n            = 2'd0;
    entry_o.data = '0;
    held_count_d = held_count_q;
    held_digit_d = held_digit_q;
    unique case (held_count_q)
      upd_pkg::HeldPct: begin
        if (nib[4] && !in_i.in_last) begin
          held_digit_d = in_i.in_byte;
          held_count_d = upd_pkg::HeldDigit;
        end else begin
          entry_o.data[0] = upd_pkg::ChPercent;
          entry_o.data[1] = p_byte;
          n               = p_emit ? 2'd2 : 2'd1;
          held_count_d    = p_hold ? upd_pkg::HeldPct : upd_pkg::HeldNone;
        end
      end
      upd_pkg::HeldDigit: begin
        held_digit_d = '0;
        if (nib[4]) begin
          entry_o.data[0] = {(hi_nib[4] ? hi_nib[3:0] : 4'd0), nib[3:0]};
          n               = 2'd1;
          held_count_d    = upd_pkg::HeldNone;
        end else begin
          entry_o.data[0] = upd_pkg::ChPercent;
          entry_o.data[1] = held_digit_q;
          entry_o.data[2] = p_byte;
          n               = p_emit ? 2'd3 : 2'd2;
          held_count_d    = p_hold ? upd_pkg::HeldPct : upd_pkg::HeldNone;
        end
      end
      default: begin
        entry_o.data[0] = p_byte;
        n               = p_emit ? 2'd1 : 2'd0;
        held_count_d    = p_hold ? upd_pkg::HeldPct : upd_pkg::HeldNone;
      end
    endcase
    // final byte flushes everything
    if (in_i.in_last) begin
      held_count_d = upd_pkg::HeldNone;
      held_digit_d = '0;
    end
    entry_o.cnt  = n;
    entry_o.last = in_i.in_last;
  end

  assign push_o = accept && (n != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_count_q <= upd_pkg::HeldNone;
      held_digit_q <= '0;
    end else if (accept) begin
      held_count_q <= held_count_d;
      held_digit_q <= held_digit_d;
    end
  end

endmodule

// ----- hdl/upd_queue.sv -----
`timescale 1ns / 1ps
// short queue of decoded byte groups between front and back end
// uses upd_pkg for the entry type

module upd_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  upd_pkg::upd_entry_t entry_i,
  input  logic                pop_i,
  output upd_pkg::upd_entry_t head_o,
  output logic                empty_o,
  output logic                full_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  upd_pkg::upd_entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CntW'(Depth));
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("pop from empty queue");
  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> count_q == $past(count_q) + 1'b1)
    else $error("queue count lost a push");
`endif

endmodule

// ----- hdl/upd_back.sv -----
`timescale 1ns / 1ps
// back end: sends the bytes of the head group one beat at a time
// uses upd_pkg and upd_out_if

module upd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  upd_pkg::upd_entry_t head_i,
  input  logic                empty_i,
  output logic                pop_o,
  upd_out_if.source           out_o
);

  logic [1:0] idx_q, idx_d;
  logic       fire, final_byte;

  assign final_byte     = (idx_q == head_i.cnt - 2'd1);
  assign out_o.valid    = !empty_i;
  assign out_o.out_byte = head_i.data[idx_q];
  assign out_o.out_last = head_i.last && final_byte;
  assign fire           = out_o.valid && out_o.ready;
  assign pop_o          = fire && final_byte;

  always_comb begin
    idx_d = idx_q;
    if (fire) begin
      idx_d = final_byte ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else begin
      idx_q <= idx_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_idx_in_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_i |-> idx_q < head_i.cnt) else $error("byte index past group");
  a_idx_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> idx_q == 2'd0) else $error("index not cleared after group");
`endif

endmodule

// ----- hdl/url_percent_decoder_top.sv -----
`timescale 1ns / 1ps
// top level of the url percent decoder: front end, group queue, back end
// uses upd_pkg, upd_in_if, upd_out_if and the upd_* modules
//
// usage
// in_i carries encoded text, one byte per beat, in_last on the final byte.
// out_o carries decoded bytes, out_last on the final decoded byte of a text.
// '+' becomes a space, '%' with two hex digits becomes one byte, a broken
// or truncated escape passes through literally.
// an input beat is taken every cycle while the queue has room; a beat
// produces zero to three output bytes, grouped into one queue entry.
// a group is offered once it reaches the head of the queue. the back end
// sends one decoded byte per cycle while the receiver is ready, and since
// output bytes never outnumber input bytes, sustained throughput is one
// beat per cycle on both sides; QueueDepth groups absorb local bursts.
// when the receiver stalls, the queue fills and in_i.ready drops once it
// holds QueueDepth groups; nothing is lost.
// reset clears the held escape state and empties the queue.

module url_percent_decoder_top #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  upd_in_if.sink    in_i,
  upd_out_if.source out_o
);

  upd_pkg::upd_entry_t push_entry, head_entry;
  logic push, pop, empty, full;

  upd_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (push_entry)
  );

  upd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .head_o  (head_entry),
    .empty_o (empty),
    .full_o  (full)
  );

  upd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head_entry),
    .empty_i (empty),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
